### rtl/base32_byte_encoder_defines.svh
// Assertion helpers used by the b32e_back encoder module.
// Both expect clk and rst_n in scope.
`ifndef BASE32_BYTE_ENCODER_DEFINES_SVH
`define BASE32_BYTE_ENCODER_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define B32E_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define B32E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/b32e_pkg.sv
`timescale 1ns / 1ps

package b32e_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [2:0] FULL_GROUP = 3'd4;
    localparam logic [3:0] KEEP_ALL   = 4'd8;
    localparam logic [2:0] LAST_SLOT  = 3'd7;
    localparam logic [4:0] NUM_LETTERS = 5'd26;

    // one 40-bit group handed from the front to the back
    typedef struct packed {
        logic [39:0] bits;
        logic [3:0]  keep;
        logic        last;
    } group_t;

    // symbol to ASCII: a..z then 1..6
    function automatic logic [7:0] sym_char(input logic [4:0] sym);
        logic [7:0] ch;
        if (sym < NUM_LETTERS)
        begin
            ch = 8'h61 + {3'b000, sym};
        end
        else
        begin
            ch = 8'h31 + {3'b000, sym - NUM_LETTERS};
        end
        return ch;
    endfunction

    // symbols kept for a final group of 1..4 bytes
    function automatic logic [3:0] kept_symbols(input logic [2:0] nbytes);
        logic [3:0] keep;
        case (nbytes)
            3'd1:    keep = 4'd2;
            3'd2:    keep = 4'd4;
            3'd3:    keep = 4'd5;
            3'd4:    keep = 4'd7;
            default: keep = KEEP_ALL;
        endcase
        return keep;
    endfunction

endpackage

### rtl/b32e_stream_if.sv
`timescale 1ns / 1ps

interface b32e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

### rtl/b32e_front.sv
`timescale 1ns / 1ps

module b32e_front
(
    input  logic                clk,
    input  logic                rst_n,
    b32e_byte_if.sink           bytes,
    output logic                grp_valid,
    input  logic                grp_ready,
    output b32e_pkg::group_t    grp
);

    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [7:0] pend_reg [4];
    logic       accept;
    logic       completes;
    logic [7:0] g [5];

    assign bytes.ready = grp_ready;
    assign accept      = bytes.valid && bytes.ready;
    assign completes   = bytes.final_byte || (count_reg == b32e_pkg::FULL_GROUP);
    assign grp_valid   = accept && completes;

    // zero-filled group: buffered bytes, then the new byte, then zeros
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            if (k < 4 && 3'(k) < count_reg)
            begin
                g[k] = pend_reg[k % 4];
            end
            else if (3'(k) == count_reg)
            begin
                g[k] = bytes.data_byte;
            end
            else
            begin
                g[k] = 8'h00;
            end
        end
        grp.bits = {g[0], g[1], g[2], g[3], g[4]};
        grp.last = bytes.final_byte;
        if (count_reg == b32e_pkg::FULL_GROUP)
        begin
            grp.keep = b32e_pkg::KEEP_ALL;
        end
        else
        begin
            grp.keep = b32e_pkg::kept_symbols(count_reg + 3'd1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = completes ? 3'd0 : count_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !completes)
        begin
            pend_reg[count_reg[1:0]] <= bytes.data_byte;
        end
    end

endmodule

### rtl/b32e_queue.sv
`timescale 1ns / 1ps

module b32e_queue
#(
    parameter int unsigned DEPTH = b32e_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  b32e_pkg::group_t    push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output b32e_pkg::group_t    pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b32e_pkg::group_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/b32e_back.sv
`timescale 1ns / 1ps
`include "base32_byte_encoder_defines.svh"

module b32e_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grp_valid,
    output logic                grp_ready,
    input  b32e_pkg::group_t    grp,
    b32e_char_if.source         chars
);

    logic [39:0] shift_reg;
    logic [3:0]  keep_reg;
    logic        last_reg;
    logic [2:0]  idx_reg;
    logic        busy_reg;
    logic        ovalid_reg;
    logic [7:0]  ochar_reg;
    logic        olast_reg;
    logic        out_free;
    logic        emit;
    logic        load;

    assign out_free  = !ovalid_reg || chars.ready;
    assign emit      = busy_reg && out_free;
    // next group may enter as the eighth character of this one goes out
    assign grp_ready = !busy_reg || (emit && idx_reg == b32e_pkg::LAST_SLOT);
    assign load      = grp_valid && grp_ready;

    assign chars.valid     = ovalid_reg;
    assign chars.out_char  = ochar_reg;
    assign chars.last_char = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                ovalid_reg <= 1'b1;
                idx_reg    <= idx_reg + 3'd1;
            end
            else if (out_free)
            begin
                ovalid_reg <= 1'b0;
            end
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && idx_reg == b32e_pkg::LAST_SLOT)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if ({1'b0, idx_reg} < keep_reg)
            begin
                ochar_reg <= b32e_pkg::sym_char(shift_reg[39:35]);
            end
            else
            begin
                ochar_reg <= b32e_pkg::PAD_CHAR;
            end
            olast_reg <= last_reg && (idx_reg == b32e_pkg::LAST_SLOT);
        end
        if (load)
        begin
            shift_reg <= grp.bits;
            keep_reg  <= grp.keep;
            last_reg  <= grp.last;
        end
        else if (emit)
        begin
            shift_reg <= {shift_reg[34:0], 5'b00000};
        end
    end

    `B32E_ASSERT_SAME(a_load_at_boundary, load, !busy_reg || idx_reg == b32e_pkg::LAST_SLOT, "group loaded mid-group")
    `B32E_ASSERT_SAME(a_last_ends_group, chars.valid && chars.last_char, idx_reg == 3'd0, "last character not at group end")
    `B32E_ASSERT_SAME(a_keep_legal, busy_reg, keep_reg == 4'd2 || keep_reg == 4'd4 || keep_reg == 4'd5 || keep_reg == 4'd7 || keep_reg == b32e_pkg::KEEP_ALL, "bad symbol count")
    `B32E_ASSERT_NEXT(a_idle_idx_zero, !busy_reg, idx_reg == 3'd0 || busy_reg, "index left mid-group")

endmodule

### rtl/base32_byte_encoder.sv
`timescale 1ns / 1ps
// Streaming Base32 encoder: bytes in on "bytes" (final_byte flags the last one), ASCII characters
// out on "chars", one word per cycle on each side unless stalled. Every five bytes, or the final
// byte of a shorter tail, yield eight characters from the alphabet a..z, 1..6, a short tail being
// padded with '=' and last_char marking the final character of the message. The output runs at
// one character per cycle while chars.ready holds; the character emitter sets the sustained rate.
// Bytes go in with no gap while the group queue has room (QUEUE_DEPTH groups); a completed group
// passes through the queue entry, the shift register and the output register before it shows.
module base32_byte_encoder
#(
    parameter int unsigned QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    b32e_byte_if.sink   bytes,
    b32e_char_if.source chars
);

    logic             f_valid;
    logic             f_ready;
    b32e_pkg::group_t f_grp;
    logic             b_valid;
    logic             b_ready;
    b32e_pkg::group_t b_grp;

    b32e_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .grp_valid (f_valid),
        .grp_ready (f_ready),
        .grp       (f_grp)
    );

    b32e_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_grp),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_grp)
    );

    b32e_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (b_valid),
        .grp_ready (b_ready),
        .grp       (b_grp),
        .chars     (chars)
    );

endmodule
